[rtl/egcd_pkg.sv]
// Package for the extended GCD block: widths, tdata layout and the
// result type of the divide step unit. No dependencies.
package egcd_pkg;

  // Width of the signed coefficient datapath; coefficients wrap at this width.
  localparam int DATA_WIDTH = 32;

  // Operand and remainder width, and width of each output coefficient field.
  localparam int OPND_W = 31;
  localparam int COEF_W = 32;

  // Coefficients are sign-extended to this width before the low COEF_W bits go out.
  localparam int EXT_W = (DATA_WIDTH > COEF_W) ? DATA_WIDTH : COEF_W;

  // Bit counter of the divider: counts OPND_W quotient bits.
  localparam int CNT_W = $clog2(OPND_W);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((2 * OPND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COEF_W + OPND_W + 7) / 8) * 8;

  // Outputs of one quotient step: remainder and quotient times the coefficients.
  typedef struct packed {
    logic [OPND_W-1:0]     rem;
    logic [DATA_WIDTH-1:0] qs;
    logic [DATA_WIDTH-1:0] qt;
  } div_res_t;

endpackage

[rtl/egcd_divstep.sv]
// Restoring divider for one quotient step of the extended GCD block. Along
// with the quotient bits it accumulates quotient * cs and quotient * ct.
// Depends on egcd_pkg.
module egcd_divstep
  import egcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [OPND_W-1:0]     dividend_i,
  input  logic [OPND_W-1:0]     divisor_i,
  input  logic [DATA_WIDTH-1:0] cs_i,
  input  logic [DATA_WIDTH-1:0] ct_i,
  output logic                  done_o,
  output div_res_t              res_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [OPND_W-1:0]     rem_q, rem_d;
  logic [OPND_W-1:0]     quo_q, quo_d;
  logic [DATA_WIDTH-1:0] qs_q, qs_d;
  logic [DATA_WIDTH-1:0] qt_q, qt_d;
  logic [OPND_W:0]       trial;
  logic                  fits;

  // One quotient bit per cycle, MSB first. The coefficient products are
  // built the same way (shift, then add when the bit is set), modulo 2^DATA_WIDTH.
  always_comb begin
    trial = {rem_q, quo_q[OPND_W-1]};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = fits ? OPND_W'(trial - {1'b0, divisor_i}) : trial[OPND_W-1:0];
    quo_d = {quo_q[OPND_W-2:0], fits};
    qs_d  = {qs_q[DATA_WIDTH-2:0], 1'b0} + (fits ? cs_i : '0);
    qt_d  = {qt_q[DATA_WIDTH-2:0], 1'b0} + (fits ? ct_i : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(OPND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      qs_q  <= '0;
      qt_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      qs_q  <= qs_d;
      qt_q  <= qt_d;
    end
  end

  assign done_o    = done_q;
  assign res_o.rem = rem_q;
  assign res_o.qs  = qs_q;
  assign res_o.qt  = qt_q;

endmodule

[rtl/extended_gcd_top.sv]
// Top level of the extended GCD block: stream ports, step sequencer and
// output register. Depends on egcd_pkg and egcd_divstep.
//
// Usage:
// An item on the slave channel (s_axis) carries operand_a and operand_b.
// For each item exactly one item leaves on the master channel (m_axis):
// coeff_s, coeff_t and divisor, with coeff_s * a + coeff_t * b = divisor.
// A zero operand_b gives coeff_s = 1, coeff_t = 0, divisor = operand_a.
// Each quotient step of the Euclidean loop runs on the shared restoring
// divider, one quotient bit per cycle, followed by the coefficient update.
// An item needs up to 45 steps, and none when operand_b is zero: such an
// item goes straight to the output register. The sequencer returns to idle
// for the next item as its result is loaded into the output register.
// One item is worked on at a time; s_axis_tready is high while the
// sequencer is idle. A finished result waits in the output register, and
// the next item is accepted meanwhile; if the receiver still stalls when
// that item is done, the sequencer holds until the register is free.
// Reset clears the sequencer and the output valid; no item is kept.
module extended_gcd_top
  import egcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: operand_a (31), operand_b (31), zero padding.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: coeff_s (32), coeff_t (32), divisor (31), zero padding.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic                  start_q;
  logic                  out_valid_q;
  logic [OPND_W-1:0]     prev_r_q, cur_r_q;
  logic [DATA_WIDTH-1:0] prev_s_q, cur_s_q;
  logic [DATA_WIDTH-1:0] prev_t_q, cur_t_q;
  logic [COEF_W-1:0]     out_s_q, out_t_q;
  logic [OPND_W-1:0]     out_g_q;

  logic                  in_acc;
  logic                  out_free;
  logic [OPND_W-1:0]     in_a, in_b;
  logic                  div_done;
  div_res_t              div_res;
  logic [EXT_W-1:0]      ext_s, ext_t;

  assign in_a     = s_axis_tdata[OPND_W-1:0];
  assign in_b     = s_axis_tdata[2*OPND_W-1:OPND_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Coefficients wrap at DATA_WIDTH and are sign-extended to the output field.
  assign ext_s = EXT_W'($signed(prev_s_q));
  assign ext_t = EXT_W'($signed(prev_t_q));

  egcd_divstep u_divstep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (prev_r_q),
    .divisor_i  (cur_r_q),
    .cs_i       (cur_s_q),
    .ct_i       (cur_t_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == ST_IDLE && in_acc && in_b != '0) ||
                 (state_q == ST_RUN && div_done && div_res.rem != '0);
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_b == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (div_done && div_res.rem == '0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Euclid state and the output register carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      prev_r_q <= in_a;
      cur_r_q  <= in_b;
      prev_s_q <= DATA_WIDTH'(1);
      cur_s_q  <= '0;
      prev_t_q <= '0;
      cur_t_q  <= DATA_WIDTH'(1);
    end else if (state_q == ST_RUN && div_done) begin
      prev_r_q <= cur_r_q;
      cur_r_q  <= div_res.rem;
      prev_s_q <= cur_s_q;
      cur_s_q  <= prev_s_q - div_res.qs;
      prev_t_q <= cur_t_q;
      cur_t_q  <= prev_t_q - div_res.qt;
    end
    if (state_q == ST_DONE && out_free) begin
      out_s_q <= ext_s[COEF_W-1:0];
      out_t_q <= ext_t[COEF_W-1:0];
      out_g_q <= prev_r_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_g_q, out_t_q, out_s_q});

endmodule

[tb/extended_gcd_top_test.sv]
// Self-checking testbench for extended_gcd_top: drives operand pairs on the slave
// stream and checks gcd and Bezout coefficients against its own model of the block.
// Depends on egcd_pkg and the extended_gcd_top RTL.
`timescale 1ns / 100ps

module extended_gcd_top_test;
  import egcd_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0] s;
    logic [COEF_W-1:0] t;
    logic [OPND_W-1:0] g;
  } bezout_t;

  class gcd_scoreboard;
    bezout_t pending_q[$];
    int      errors;

    // Coefficients wrap at DATA_WIDTH, are sign-extended and then cut to COEF_W bits.
    function logic [COEF_W-1:0] fit_coeff(longint v);
      longint w;
      w = (v <<< (64 - DATA_WIDTH)) >>> (64 - DATA_WIDTH);
      return w[COEF_W-1:0];
    endfunction

    // Extended Euclid; a zero b leaves the loop at once with s = 1, t = 0, g = a.
    function bezout_t solve_bezout(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      longint unsigned r0, r1, q, nr;
      longint          s0, s1, t0, t1, ns, nt;
      bezout_t         res;
      r0 = a;
      r1 = b;
      s0 = 1;
      s1 = 0;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q  = r0 / r1;
        nr = r0 - q * r1;
        ns = s0 - longint'(q) * s1;
        nt = t0 - longint'(q) * t1;
        r0 = r1;
        r1 = nr;
        s0 = s1;
        s1 = ns;
        t0 = t1;
        t1 = nt;
      end
      res.s = fit_coeff(s0);
      res.t = fit_coeff(t0);
      res.g = r0[OPND_W-1:0];
      return res;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      end
    endfunction

    function void note_operands(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      pending_q.push_back(solve_bezout(a, b));
    endfunction

    function void check_result(bezout_t got);
      bezout_t want;
      if (pending_q.size() == 0) begin
        flag("unrequested result", '0, {got.t, got.s});
        return;
      end
      want = pending_q.pop_front();
      if (got.s !== want.s) flag("coeff_s", 64'(want.s), 64'(got.s));
      if (got.t !== want.t) flag("coeff_t", 64'(want.t), 64'(got.t));
      if (got.g !== want.g) flag("divisor", 64'(want.g), 64'(got.g));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // Fields from bit 0 up: operand_a (31), operand_b (31), zero padding.
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // Fields from bit 0 up: coeff_s (32), coeff_t (32), divisor (31), zero padding.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  gcd_scoreboard sb = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int rx_hold_left;

  extended_gcd_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_req   = 0;
    rx_hold_left  = 0;
  end

  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_operands(s_axis_tdata[OPND_W-1:0], s_axis_tdata[2*OPND_W-1:OPND_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result({m_axis_tdata[COEF_W-1:0], m_axis_tdata[2*COEF_W-1:COEF_W],
                         m_axis_tdata[2*COEF_W+OPND_W-1:2*COEF_W]});
      end
    end
  end

  // Keeps tvalid high into the next item unless the sender decides to idle.
  task automatic send_operands(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
    logic [IN_TDATA_W-1:0] word;
    word                       = '0;
    word[OPND_W-1:0]           = a;
    word[2*OPND_W-1:OPND_W]    = b;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Consecutive Fibonacci numbers need the most quotient steps.
  task automatic fib_pair(int k, output logic [OPND_W-1:0] lo, output logic [OPND_W-1:0] hi);
    longint unsigned x, y, z;
    x = 1;
    y = 1;
    repeat (k) begin
      z = x + y;
      x = y;
      y = z;
    end
    lo = x[OPND_W-1:0];
    hi = y[OPND_W-1:0];
  endtask

  task automatic send_random(int count);
    logic [OPND_W-1:0] a, b, lo, hi;
    int                sel, g;
    repeat (count) begin
      sel = $urandom_range(99);
      a   = OPND_W'($urandom);
      b   = OPND_W'($urandom);
      if (sel >= 55 && sel < 70) begin
        a = OPND_W'($urandom_range(255));
        b = OPND_W'($urandom_range(255));
      end else if (sel >= 70 && sel < 82) begin
        g = $urandom_range(65535, 1);
        a = OPND_W'(g * $urandom_range(32767));
        b = OPND_W'(g * $urandom_range(32767));
      end else if (sel >= 82 && sel < 90) begin
        if ($urandom_range(1)) a = '0;
        else b = '0;
      end else if (sel >= 90 && sel < 95) begin
        fib_pair($urandom_range(44), lo, hi);
        if ($urandom_range(1)) begin
          a = hi;
          b = lo;
        end else begin
          a = lo;
          b = hi;
        end
      end else if (sel >= 95) begin
        b = $urandom_range(1) ? a : a >> $urandom_range(30);
      end
      send_operands(a, b);
    end
  endtask

  initial begin
    logic [OPND_W-1:0] lo, hi;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 32;
    rx_idle_pct = 56;
    send_operands('0, '0);
    send_operands(31'h7fffffff, '0);
    send_operands('0, 31'h7fffffff);
    send_operands(31'd1, '0);
    send_operands('0, 31'd1);
    send_operands(31'd1, 31'd1);
    send_operands(31'h7fffffff, 31'h7fffffff);
    send_operands(31'h7fffffff, 31'd1);
    send_operands(31'd1, 31'h7fffffff);
    send_operands(31'h7fffffff, 31'h7ffffffe);
    send_operands(31'h7ffffffe, 31'h7fffffff);
    send_operands(31'd12, 31'd18);
    send_operands(31'd240, 31'd46);
    fib_pair(44, lo, hi);
    send_operands(hi, lo);
    send_operands(lo, hi);
    send_operands(31'h40000000, 31'h20000000);
    send_operands(31'h55555555, 31'h2aaaaaaa);
    send_operands(31'h2aaaaaaa, 31'h55555555);
    send_operands(31'h7fffffff, 31'd2147483629);
    send_operands(31'd6, '0);
    send_operands(31'd13, 31'd13);
    send_random(130);
    drain();

    tx_idle_pct = 56;
    rx_idle_pct = 32;
    send_random(130);
    drain();

    // Long receiver hold-off: the output register and the sequencer fill and
    // the slave side stalls while items keep being offered.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 6000;
    send_random(130);
    drain();

    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("extended_gcd_top regression: pass");
    end else begin
      $display("extended_gcd_top regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("extended_gcd_top regression: fail");
    $finish;
  end

endmodule
